>>> sv/chrbs_pkg.sv
// ----------------------------------------------------------------------------
// chrbs_pkg: shared types and constants of the pattern-bank mapper
// Request codes, register addresses, field widths and the item struct
// passed from the top level to the bank and interrupt sections.
// ----------------------------------------------------------------------------
package chrbs_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = 3;
   localparam int MASK_W      = 10;
   localparam int ROM_W       = 20;
   localparam int CPU_ADDR_W  = 16;
   localparam int DATA_W      = 8;
   localparam int PAT_ADDR_W  = 13;
   localparam int PAGE_W      = 10;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

   localparam logic [CPU_ADDR_W-1:0] ADDR_SIZE_MODE = 16'h5101;
   localparam logic [CPU_ADDR_W-1:0] ADDR_HIGH_BITS = 16'h5130;
   localparam logic [CPU_ADDR_W-1:0] ADDR_SPR_FIRST = 16'h5120;
   localparam logic [CPU_ADDR_W-1:0] ADDR_SPR_LAST  = 16'h5127;
   localparam logic [CPU_ADDR_W-1:0] ADDR_BG_FIRST  = 16'h5128;
   localparam logic [CPU_ADDR_W-1:0] ADDR_BG_LAST   = 16'h512B;
   localparam logic [CPU_ADDR_W-1:0] ADDR_COMPARE   = 16'h5203;
   localparam logic [CPU_ADDR_W-1:0] ADDR_STATUS    = 16'h5204;
   localparam logic [CPU_ADDR_W-1:0] ADDR_PROD_LO   = 16'h5205;
   localparam logic [CPU_ADDR_W-1:0] ADDR_PROD_HI   = 16'h5206;

   localparam int ENABLE_BIT  = 7;
   localparam int PENDING_BIT = 7;
   localparam int FRAME_BIT   = 6;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_FETCH = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type          kind;
      logic [CPU_ADDR_W-1:0] cpu_address;
      logic [DATA_W-1:0]     write_data;
      logic                  in_frame;
      logic [PAT_ADDR_W-1:0] pattern_address;
      logic                  sprite_fetch;
      logic                  tall_sprites;
   } req_item_type;

   typedef struct packed {
      logic         fire;
      req_item_type item;
   } step_type;

endpackage

>>> sv/chrbs_banks.sv
// ----------------------------------------------------------------------------
// chrbs_banks: pattern bank slots and fetch address mapping
// Holds the sprite and background slot sets, fills them from bank writes
// according to the size mode, and maps a fetch to a ROM address.
// ----------------------------------------------------------------------------
module chrbs_banks #(
   parameter int BANK_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chrbs_pkg::step_type          step,
   input  logic [chrbs_pkg::MASK_W-1:0] bank_mask,
   output logic [chrbs_pkg::ROM_W-1:0]  rom_address
);
   import chrbs_pkg::*;

   logic [BANK_BITS-1:0] spr_ff [SLOTS];
   logic [BANK_BITS-1:0] spr_in [SLOTS];
   logic [BANK_BITS-1:0] bg_ff  [SLOTS];
   logic [BANK_BITS-1:0] bg_in  [SLOTS];
   logic [1:0]           mode_ff, mode_in;
   logic [1:0]           high_ff, high_in;
   logic                 bg_last_ff, bg_last_in;

   logic                  is_wr;
   logic                  spr_hit, bg_hit;
   logic                  spr_trig, bg_trig;
   logic [SLOT_W-1:0]     spr_r, spr_low;
   logic [1:0]            bg_r, bg_low, spr_sh, bg_sh;
   logic [MASK_W-1:0]     number;
   logic [PAT_ADDR_W-1:0] spr_num, bg_num, mask_ext;
   logic [PAT_ADDR_W-1:0] spr_val, bg_val;
   logic [SLOT_W-1:0]     slot;
   logic [SLOT_W-1:0]     fetch_slot;
   logic                  use_bg;
   logic [BANK_BITS-1:0]  bank;
   logic [BANK_BITS+PAGE_W-1:0] wide;

   always_comb begin
      is_wr   = step.fire && (step.item.kind == REQ_WRITE);
      spr_hit = is_wr && (step.item.cpu_address inside {[ADDR_SPR_FIRST:ADDR_SPR_LAST]});
      bg_hit  = is_wr && (step.item.cpu_address inside {[ADDR_BG_FIRST:ADDR_BG_LAST]});
      spr_r   = step.item.cpu_address[SLOT_W-1:0];
      bg_r    = step.item.cpu_address[1:0];
      number  = {high_ff, step.item.write_data};

      spr_sh  = 2'd3 - mode_ff;
      spr_low = 3'b111 >> mode_ff;
      if (mode_ff == 2'd0) begin
         bg_sh  = 2'd2;
         bg_low = 2'b11;
      end else begin
         bg_sh  = 2'd3 - mode_ff;
         bg_low = 2'(3'b111 >> mode_ff);
      end
      spr_trig = (spr_r & spr_low) == spr_low;
      bg_trig  = (bg_r & bg_low) == bg_low;
      spr_num  = PAT_ADDR_W'(number) << spr_sh;
      bg_num   = PAT_ADDR_W'(number) << bg_sh;
      mask_ext = PAT_ADDR_W'(bank_mask);

      mode_in    = mode_ff;
      high_in    = high_ff;
      bg_last_in = bg_last_ff;
      if (spr_hit) begin
         bg_last_in = 1'b0;
      end
      if (bg_hit) begin
         bg_last_in = 1'b1;
      end
      if (is_wr && (step.item.cpu_address == ADDR_SIZE_MODE)) begin
         mode_in = step.item.write_data[1:0];
      end
      if (is_wr && (step.item.cpu_address == ADDR_HIGH_BITS)) begin
         high_in = step.item.write_data[1:0];
      end

      for (int j = 0; j < SLOTS; j++) begin
         slot    = SLOT_W'(j);
         spr_val = (spr_num | PAT_ADDR_W'(slot & spr_low)) & mask_ext;
         bg_val  = (bg_num | PAT_ADDR_W'(slot[1:0] & bg_low)) & mask_ext;
         spr_in[j] = spr_ff[j];
         bg_in[j]  = bg_ff[j];
         if (spr_hit && spr_trig && ((slot & ~spr_low) == (spr_r & ~spr_low))) begin
            spr_in[j] = spr_val[BANK_BITS-1:0];
         end
         if (bg_hit && bg_trig && ((slot[1:0] & ~bg_low) == (bg_r & ~bg_low))) begin
            bg_in[j] = bg_val[BANK_BITS-1:0];
         end
      end

      fetch_slot = step.item.pattern_address[PAT_ADDR_W-1:PAGE_W];
      use_bg     = step.item.tall_sprites ? !step.item.sprite_fetch : bg_last_ff;
      bank       = use_bg ? bg_ff[fetch_slot] : spr_ff[fetch_slot];
      wide       = {bank, step.item.pattern_address[PAGE_W-1:0]};
      if (step.item.kind == REQ_FETCH) begin
         rom_address = ROM_W'(wide);
      end else begin
         rom_address = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SLOTS; j++) begin
            spr_ff[j] <= BANK_BITS'(j);
            bg_ff[j]  <= BANK_BITS'(j);
         end
         mode_ff    <= '0;
         high_ff    <= '0;
         bg_last_ff <= 1'b0;
      end else begin
         for (int j = 0; j < SLOTS; j++) begin
            spr_ff[j] <= spr_in[j];
            bg_ff[j]  <= bg_in[j];
         end
         mode_ff    <= mode_in;
         high_ff    <= high_in;
         bg_last_ff <= bg_last_in;
      end
   end

endmodule

>>> sv/chrbs_irq.sv
// ----------------------------------------------------------------------------
// chrbs_irq: scanline interrupt, status and multiplier registers
// Counts scanline ticks against a compare line, keeps the pending flag and
// the interrupt line, and answers CPU reads of status and the product.
// ----------------------------------------------------------------------------
module chrbs_irq (
   input  logic                         clock,
   input  logic                         reset,
   input  chrbs_pkg::step_type          step,
   output logic [chrbs_pkg::DATA_W-1:0] read_data,
   output logic                         irq_level
);
   import chrbs_pkg::*;

   logic [DATA_W-1:0]   compare_ff, compare_in;
   logic                enable_ff, enable_in;
   logic [DATA_W-1:0]   count_ff, count_in;
   logic                pending_ff, pending_in;
   logic                frame_ff, frame_in;
   logic [DATA_W-1:0]   fa_ff, fa_in;
   logic [DATA_W-1:0]   fb_ff, fb_in;
   logic                line_ff, line_in;
   logic [2*DATA_W-1:0] product;
   logic [DATA_W-1:0]   count_inc;
   logic                is_wr, is_rd, is_tick;

   always_comb begin
      is_wr     = step.fire && (step.item.kind == REQ_WRITE);
      is_rd     = step.item.kind == REQ_READ;
      is_tick   = step.fire && (step.item.kind == REQ_TICK);
      product   = {{DATA_W{1'b0}}, fa_ff} * {{DATA_W{1'b0}}, fb_ff};
      count_inc = count_ff + 8'd1;

      compare_in = compare_ff;
      enable_in  = enable_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      frame_in   = frame_ff;
      fa_in      = fa_ff;
      fb_in      = fb_ff;
      line_in    = line_ff;
      read_data  = '0;

      if (is_wr) begin
         case (step.item.cpu_address)
            ADDR_COMPARE: compare_in = step.item.write_data;
            ADDR_STATUS:  enable_in  = step.item.write_data[ENABLE_BIT];
            ADDR_PROD_LO: fa_in      = step.item.write_data;
            ADDR_PROD_HI: fb_in      = step.item.write_data;
            default: ;
         endcase
      end

      if (is_rd) begin
         case (step.item.cpu_address)
            ADDR_STATUS: begin
               read_data[PENDING_BIT] = pending_ff;
               read_data[FRAME_BIT]   = frame_ff;
               if (step.fire) begin
                  pending_in = 1'b0;
                  line_in    = 1'b0;
               end
            end
            ADDR_PROD_LO: read_data = product[DATA_W-1:0];
            ADDR_PROD_HI: read_data = product[2*DATA_W-1:DATA_W];
            default:      read_data = '0;
         endcase
      end

      if (is_tick) begin
         frame_in = step.item.in_frame;
         if (!step.item.in_frame) begin
            count_in   = '0;
            pending_in = 1'b0;
            line_in    = 1'b0;
         end else begin
            count_in = count_inc;
            if (count_inc == compare_ff) begin
               pending_in = 1'b1;
               if (enable_ff) begin
                  line_in = 1'b1;
               end
            end
         end
      end

      irq_level = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= '0;
         enable_ff  <= 1'b0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         frame_ff   <= 1'b0;
         fa_ff      <= '0;
         fb_ff      <= '0;
         line_ff    <= 1'b0;
      end else begin
         compare_ff <= compare_in;
         enable_ff  <= enable_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         frame_ff   <= frame_in;
         fa_ff      <= fa_in;
         fb_ff      <= fb_in;
         line_ff    <= line_in;
      end
   end

`ifndef ASSERT_OFF
   a_line_needs_pending: assert property (@(posedge clock) disable iff (reset)
      line_ff |-> pending_ff)
      else $error("Interrupt line is high without a pending flag.");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> frame_ff)
      else $error("Scanline counter is running outside the frame.");

   a_frame_exit_clears: assert property (@(posedge clock) disable iff (reset)
      (is_tick && !step.item.in_frame) |=> ((count_ff == '0) && !pending_ff && !line_ff))
      else $error("Leaving the frame did not clear the counter and interrupt.");
`endif

endmodule

>>> sv/chr_bank_switch_scanline_irq.sv
// ----------------------------------------------------------------------------
// chr_bank_switch_scanline_irq: pattern-bank mapper with scanline interrupt
// Decodes CPU writes and reads, scanline ticks and pattern fetches through
// an input register and a result register, with an APB register port.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | type, address, data, fetch info
//   rsp     | out       | rsp_valid/rsp_ready  | read_data, rom address, irq_out
//   csr     | in/out    | psel/penable/pready  | chr_bank_mask at byte 0
//
// One item is accepted per cycle while req_ready is high; each result passes
// through the input register, then the result register, before it is presented.
// Reset is synchronous and restores all slots and control registers only.
// While the result waits, one more item is held in the input register;
// req_ready falls only when both registers are full.
// ----------------------------------------------------------------------------
module chr_bank_switch_scanline_irq #(
   parameter int BANK_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [chrbs_pkg::CPU_ADDR_W-1:0] req_cpu_address,
   input  logic [chrbs_pkg::DATA_W-1:0]     req_write_data,
   input  logic                             req_in_frame,
   input  logic [chrbs_pkg::PAT_ADDR_W-1:0] req_pattern_address,
   input  logic                             req_sprite_fetch,
   input  logic                             req_tall_sprites,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [chrbs_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [chrbs_pkg::ROM_W-1:0]      rsp_pattern_rom_address,
   output logic                             rsp_irq_out,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [chrbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [chrbs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [chrbs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import chrbs_pkg::*;

   req_item_type        item_ff, item_in;
   logic                item_vld_ff, item_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [DATA_W-1:0]   rd_ff, rd_in;
   logic [ROM_W-1:0]    rom_ff, rom_in;
   logic                irq_ff, irq_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                advance;
   logic                csr_wr;
   step_type            step;

   always_comb begin
      advance     = item_vld_ff && (!rsp_vld_ff || rsp_ready);
      req_ready   = !item_vld_ff || advance;
      step.fire   = advance;
      step.item   = item_ff;

      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      if (advance) begin
         item_vld_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         item_vld_in          = 1'b1;
         item_in.kind            = req_kind_type'(req_type);
         item_in.cpu_address     = req_cpu_address;
         item_in.write_data      = req_write_data;
         item_in.in_frame        = req_in_frame;
         item_in.pattern_address = req_pattern_address;
         item_in.sprite_fetch    = req_sprite_fetch;
         item_in.tall_sprites    = req_tall_sprites;
      end

      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (advance) begin
         rsp_vld_in = 1'b1;
      end

      pready  = 1'b1;
      csr_wr  = psel && penable && pwrite && pready && !paddr[CSR_ADDR_W-1];
      mask_in = csr_wr ? pwdata[MASK_W-1:0] : mask_ff;
      prdata  = paddr[CSR_ADDR_W-1] ? '0 : CSR_DATA_W'(mask_ff);
   end

   chrbs_banks #(
      .BANK_BITS (BANK_BITS)
   ) u_banks (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .bank_mask   (mask_ff),
      .rom_address (rom_in)
   );

   chrbs_irq u_irq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .read_data (rd_in),
      .irq_level (irq_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         mask_ff     <= MASK_RESET;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         mask_ff     <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         rd_ff  <= rd_in;
         rom_ff <= rom_in;
         irq_ff <= irq_in;
      end
   end

   assign rsp_valid               = rsp_vld_ff;
   assign rsp_read_data           = rd_ff;
   assign rsp_pattern_rom_address = rom_ff;
   assign rsp_irq_out             = irq_ff;

`ifndef ASSERT_OFF
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_vld_ff && rsp_vld_ff))
      else $error("Input stalled while a register stage is free.");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("An item left the input register without a result.");

   a_one_payload_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rd_ff == '0) || (rom_ff == '0)))
      else $error("Result carries both read data and a ROM address.");
`endif

endmodule

>>> verif/chr_bank_switch_scanline_irq_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_bank_switch_scanline_irq_tb: self-checking bench for the pattern-bank mapper
// Drives CPU writes and reads, scanline ticks and pattern fetches through the
// request channel. A mirror of the mapper state predicts every result item,
// and each result is checked field by field against it. The bench covers a
// directed opening, random phases with sender and receiver stalls, and
// several bank mask settings.
// ----------------------------------------------------------------------------
module chr_bank_switch_scanline_irq_tb;
   import chrbs_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_ADDR = 3'd0;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [ROM_W-1:0]  rom_address;
      logic              irq;
   } rsp_fields_type;

   class chr_mapper_mirror;
      logic [MASK_W-1:0] bank_mask;
      logic [MASK_W-1:0] sprite_slot [SLOTS];
      logic [MASK_W-1:0] bg_slot [SLOTS];
      logic [1:0]        size_mode;
      logic [1:0]        high_bits;
      bit                bg_last;
      bit                irq_en;
      bit                pending;
      bit                frame_flag;
      bit                line;
      logic [7:0]        compare_line;
      logic [7:0]        line_count;
      logic [7:0]        factor_a;
      logic [7:0]        factor_b;
      rsp_fields_type    pending_results [$];
      int                errors;

      function new();
         bank_mask = MASK_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            sprite_slot[i] = MASK_W'(i) & bank_mask;
            bg_slot[i] = MASK_W'(i) & bank_mask;
         end
         size_mode = '0;
         high_bits = '0;
         bg_last = 0;
         irq_en = 0;
         pending = 0;
         frame_flag = 0;
         line = 0;
         compare_line = '0;
         line_count = '0;
         factor_a = '0;
         factor_b = '0;
         errors = 0;
      endfunction

      function void fill_slots(bit to_bg, int unsigned first, int unsigned cnt,
                               int unsigned shift, int unsigned number);
         logic [MASK_W-1:0] bank;
         for (int unsigned i = 0; i < cnt; i++) begin
            bank = MASK_W'(((number << shift) + i) & bank_mask);
            if (to_bg) begin
               bg_slot[(first + i) % SLOTS] = bank;
            end else begin
               sprite_slot[(first + i) % SLOTS] = bank;
            end
         end
      endfunction

      function void write_reg(logic [CPU_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         int unsigned number;
         int unsigned r;
         int unsigned cnt;
         int unsigned shift;
         number = {high_bits, data};
         if (addr >= ADDR_SPR_FIRST && addr <= ADDR_SPR_LAST) begin
            r = addr - ADDR_SPR_FIRST;
            cnt = 8 >> size_mode;
            bg_last = 0;
            if ((r + 1) % cnt == 0) begin
               fill_slots(0, r + 1 - cnt, cnt, 3 - size_mode, number);
            end
         end else if (addr >= ADDR_BG_FIRST && addr <= ADDR_BG_LAST) begin
            // The background set always fills both halves of the slot array.
            r = addr - ADDR_BG_FIRST;
            cnt = (size_mode == 0) ? 4 : (8 >> size_mode);
            shift = (size_mode == 0) ? 2 : 3 - size_mode;
            bg_last = 1;
            if ((r + 1) % cnt == 0) begin
               fill_slots(1, r + 1 - cnt, cnt, shift, number);
               fill_slots(1, r + 5 - cnt, cnt, shift, number);
            end
         end else begin
            case (addr)
               ADDR_SIZE_MODE: size_mode = data[1:0];
               ADDR_HIGH_BITS: high_bits = data[1:0];
               ADDR_COMPARE:   compare_line = data;
               ADDR_STATUS:    irq_en = data[ENABLE_BIT];
               ADDR_PROD_LO:   factor_a = data;
               ADDR_PROD_HI:   factor_b = data;
               default: ;
            endcase
         end
      endfunction

      function logic [DATA_W-1:0] read_reg(logic [CPU_ADDR_W-1:0] addr);
         logic [15:0]       product;
         logic [DATA_W-1:0] value;
         product = factor_a * factor_b;
         value = '0;
         case (addr)
            ADDR_STATUS: begin
               value[PENDING_BIT] = pending;
               value[FRAME_BIT] = frame_flag;
               pending = 0;
               line = 0;
            end
            ADDR_PROD_LO: value = product[7:0];
            ADDR_PROD_HI: value = product[15:8];
            default: value = '0;
         endcase
         return value;
      endfunction

      function void advance_scanline(bit frame_on);
         frame_flag = frame_on;
         if (!frame_on) begin
            line_count = '0;
            pending = 0;
            line = 0;
         end else begin
            line_count = line_count + 8'd1;
            if (line_count == compare_line) begin
               pending = 1;
               if (irq_en) begin
                  line = 1;
               end
            end
         end
      endfunction

      function logic [ROM_W-1:0] map_fetch(req_item_type it);
         logic [SLOT_W-1:0] slot;
         logic [MASK_W-1:0] bank;
         bit                use_bg;
         slot = it.pattern_address[PAT_ADDR_W-1:PAGE_W];
         use_bg = it.tall_sprites ? !it.sprite_fetch : bg_last;
         bank = use_bg ? bg_slot[slot] : sprite_slot[slot];
         return {bank, it.pattern_address[PAGE_W-1:0]};
      endfunction

      function void note_request(req_item_type it);
         rsp_fields_type result;
         result = '0;
         case (it.kind)
            REQ_WRITE: write_reg(it.cpu_address, it.write_data);
            REQ_READ:  result.read_data = read_reg(it.cpu_address);
            REQ_TICK:  advance_scanline(it.in_frame);
            REQ_FETCH: result.rom_address = map_fetch(it);
            default: ;
         endcase
         result.irq = line;
         pending_results.push_back(result);
      endfunction

      function void check_result(logic [DATA_W-1:0] rd, logic [ROM_W-1:0] rom, logic irq);
         rsp_fields_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none outstanding: read_data %h rom %h irq %b",
                     $time, rd, rom, irq);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (rd !== want.read_data) begin
            $display("%0t: read_data expected %h, got %h", $time, want.read_data, rd);
            errors++;
         end
         if (rom !== want.rom_address) begin
            $display("%0t: pattern_rom_address expected %h, got %h",
                     $time, want.rom_address, rom);
            errors++;
         end
         if (irq !== want.irq) begin
            $display("%0t: irq_out expected %b, got %b", $time, want.irq, irq);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type = 2'd0;
   logic [CPU_ADDR_W-1:0] req_cpu_address = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  req_in_frame = 1'b0;
   logic [PAT_ADDR_W-1:0] req_pattern_address = '0;
   logic                  req_sprite_fetch = 1'b0;
   logic                  req_tall_sprites = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_W-1:0]     rsp_read_data;
   logic [ROM_W-1:0]      rsp_pattern_rom_address;
   logic                  rsp_irq_out;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   chr_mapper_mirror sb;

   chr_bank_switch_scanline_irq dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_type                (req_type),
      .req_cpu_address         (req_cpu_address),
      .req_write_data          (req_write_data),
      .req_in_frame            (req_in_frame),
      .req_pattern_address     (req_pattern_address),
      .req_sprite_fetch        (req_sprite_fetch),
      .req_tall_sprites        (req_tall_sprites),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_read_data           (rsp_read_data),
      .rsp_pattern_rom_address (rsp_pattern_rom_address),
      .rsp_irq_out             (rsp_irq_out),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_read_data, rsp_pattern_rom_address, rsp_irq_out);
         end
         if (req_valid && req_ready) begin
            sb.note_request({req_type, req_cpu_address, req_write_data, req_in_frame,
                             req_pattern_address, req_sprite_fetch, req_tall_sprites});
         end
      end
   end

   function automatic req_item_type random_item();
      req_item_type it;
      logic [31:0]  a;
      logic [31:0]  b;
      a = $urandom;
      b = $urandom;
      it.kind = REQ_FETCH;
      it.cpu_address = a[15:0];
      it.write_data = a[23:16];
      it.in_frame = a[24];
      it.pattern_address = b[12:0];
      it.sprite_fetch = b[13];
      it.tall_sprites = b[14];
      return it;
   endfunction

   task automatic send_req(req_item_type it);
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_cpu_address <= it.cpu_address;
      req_write_data <= it.write_data;
      req_in_frame <= it.in_frame;
      req_pattern_address <= it.pattern_address;
      req_sprite_fetch <= it.sprite_fetch;
      req_tall_sprites <= it.tall_sprites;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic cpu_write(logic [CPU_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      req_item_type it;
      it = random_item();
      it.kind = REQ_WRITE;
      it.cpu_address = addr;
      it.write_data = data;
      send_req(it);
   endtask

   task automatic cpu_read(logic [CPU_ADDR_W-1:0] addr);
      req_item_type it;
      it = random_item();
      it.kind = REQ_READ;
      it.cpu_address = addr;
      send_req(it);
   endtask

   task automatic scanline_tick(bit frame_on);
      req_item_type it;
      it = random_item();
      it.kind = REQ_TICK;
      it.in_frame = frame_on;
      send_req(it);
   endtask

   task automatic pattern_fetch(logic [PAT_ADDR_W-1:0] addr, bit spr, bit tall);
      req_item_type it;
      it = random_item();
      it.kind = REQ_FETCH;
      it.pattern_address = addr;
      it.sprite_fetch = spr;
      it.tall_sprites = tall;
      send_req(it);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bank_mask(logic [MASK_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[MASK_W-1:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_MASK_ADDR;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.bank_mask = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {{(CSR_DATA_W - MASK_W){1'b0}}, value}) begin
         $display("%0t: bank mask readback expected %h, got %h", $time, value, prdata);
         sb.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_req(bit keep_frame);
      int unsigned           sel;
      int unsigned           pick;
      logic [31:0]           bits;
      logic [CPU_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]     data;
      sel = $urandom_range(99);
      pick = $urandom_range(19);
      bits = $urandom;
      data = bits[7:0];
      if (sel < 30) begin
         if (pick == 0) begin
            addr = ADDR_SIZE_MODE;
         end else if (pick == 1) begin
            addr = ADDR_HIGH_BITS;
         end else if (pick < 10) begin
            addr = ADDR_SPR_FIRST + 16'(pick - 2);
         end else if (pick < 14) begin
            addr = ADDR_BG_FIRST + 16'(pick - 10);
         end else if (pick == 14) begin
            // Small compare values keep matches frequent between frame exits.
            addr = ADDR_COMPARE;
            if (keep_frame) begin
               data = '0;
            end else if (bits[31]) begin
               data = {4'h0, bits[11:8]};
            end
         end else if (pick == 15) begin
            addr = ADDR_STATUS;
         end else if (pick == 16) begin
            addr = ADDR_PROD_LO;
         end else if (pick == 17) begin
            addr = ADDR_PROD_HI;
         end else if (pick == 18) begin
            addr = {4'h5, bits[27:16]};
         end else begin
            addr = bits[31:16];
         end
         cpu_write(addr, data);
      end else if (sel < 45) begin
         if (pick < 8) begin
            addr = ADDR_STATUS;
         end else if (pick < 12) begin
            addr = ADDR_PROD_LO;
         end else if (pick < 16) begin
            addr = ADDR_PROD_HI;
         end else if (pick < 18) begin
            addr = {4'h5, bits[27:16]};
         end else begin
            addr = bits[31:16];
         end
         cpu_read(addr);
      end else if (sel < 70) begin
         scanline_tick(keep_frame || pick != 0);
      end else begin
         pattern_fetch(bits[12:0], bits[13], bits[14]);
      end
   endtask

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int                phase;
      int                n;
      int                items;
      logic [MASK_W-1:0] mask_value;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_bank_mask(10'h3FF);

      pattern_fetch(13'h0000, 1'b0, 1'b0);
      pattern_fetch(13'h1FFF, 1'b0, 1'b1);
      cpu_write(ADDR_SIZE_MODE, 8'hFF);
      cpu_write(ADDR_HIGH_BITS, 8'hFF);
      cpu_write(ADDR_SPR_FIRST, 8'hFF);
      cpu_write(ADDR_BG_LAST, 8'h00);
      pattern_fetch(13'h0C00, 1'b1, 1'b0);
      pattern_fetch(13'h03FF, 1'b1, 1'b1);
      cpu_write(ADDR_SIZE_MODE, 8'h00);
      cpu_write(ADDR_SPR_LAST, 8'h81);
      cpu_write(ADDR_BG_LAST, 8'h7F);
      cpu_write(ADDR_SPR_FIRST, 8'h55);
      pattern_fetch(13'h1C00, 1'b0, 1'b0);
      cpu_write(ADDR_PROD_LO, 8'hFF);
      cpu_write(ADDR_PROD_HI, 8'hFF);
      cpu_read(ADDR_PROD_LO);
      cpu_read(ADDR_PROD_HI);
      cpu_write(ADDR_COMPARE, 8'd2);
      cpu_write(ADDR_STATUS, 8'h80);
      scanline_tick(1'b0);
      scanline_tick(1'b1);
      scanline_tick(1'b1);
      cpu_write(ADDR_STATUS, 8'h00);
      cpu_read(ADDR_STATUS);
      cpu_read(16'hFFFF);
      cpu_write(16'h0000, 8'hA5);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               mask_value = 10'h000;
               items = 180;
            end
            1: begin
               sender_idle_pct = 83;
               receiver_stall_pct = 0;
               mask_value = 10'h155;
               items = 150;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 83;
               mask_value = 10'h2AA;
               items = 180;
            end
            3: begin
               sender_idle_pct = 17;
               receiver_stall_pct = 17;
               mask_value = 10'h3FF;
               items = 180;
            end
            default: begin
               sender_idle_pct = 17;
               receiver_stall_pct = 17;
               mask_value = 10'($urandom);
               items = 400;
            end
         endcase
         wait_for_results();
         set_bank_mask(mask_value);
         if (phase == 4) begin
            // A long frame with compare zero lets the counter wrap and match.
            cpu_write(ADDR_COMPARE, 8'd0);
            cpu_write(ADDR_STATUS, 8'h80);
            scanline_tick(1'b0);
         end
         for (n = 0; n < items; n++) begin
            if (phase == 4 && $urandom_range(99) < 60) begin
               scanline_tick(1'b1);
            end else begin
               random_req(phase == 4);
            end
            if ($urandom_range(249) == 0) begin
               wait_for_results();
            end
         end
      end

      wait_for_results();
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> chr_bank_switch_scanline_irq.f
sv/chrbs_pkg.sv
sv/chrbs_banks.sv
sv/chrbs_irq.sv
sv/chr_bank_switch_scanline_irq.sv
verif/chr_bank_switch_scanline_irq_tb.sv
